// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the oscillator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: src/wto_pkg.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Widths, register indexes, shared structs and sine polynomial coefficients.
// ----------------------------------------------------------------------------
package wto_pkg;

	localparam int TABLE_POINTS_DEF = 2048;

	localparam int FREQ_W     = 24;
	localparam int AMP_W      = 16;
	localparam int SMP_W      = 18;
	localparam int PHASE_W    = 32;
	localparam int SHAPE_W    = 17;
	localparam int LOFF_W     = 16;
	localparam int RATE_W     = 18;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int ENT_W      = 16;
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 64;
	localparam int Q30_W      = 35;
	localparam int DIV_NUM_W  = 48;
	localparam int DIV_DEN_W  = 18;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	localparam logic signed [31:0] SIN_C1 = 32'sd1686629713;
	localparam logic signed [31:0] SIN_C3 = -32'sd693598686;
	localparam logic signed [31:0] SIN_C5 = 32'sd85569306;
	localparam logic signed [31:0] SIN_C7 = -32'sd5026995;
	localparam logic signed [31:0] SIN_C9 = 32'sd172273;

	localparam logic signed [ENT_W-1:0] ENT_ONE = 16'sd16384;

	typedef enum logic [MODE_W-1:0] {
		WAVE_SINE   = 2'd0,
		WAVE_SQUARE = 2'd1,
		WAVE_SAW    = 2'd2,
		WAVE_SILENT = 2'd3
	} wave_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAVE_MODE    = 3'd0,
		REG_SHAPE_PARAM  = 3'd1,
		REG_PHASE_START  = 3'd2,
		REG_LEVEL_OFFSET = 3'd3,
		REG_SAMPLE_RATE  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		wave_t                     wave_mode;
		logic [SHAPE_W-1:0]        shape_param;
		logic [PHASE_W-1:0]        phase_start;
		logic signed [LOFF_W-1:0]  level_offset;
		logic [RATE_W-1:0]         sample_rate;
	} cfg_t;

	typedef struct packed {
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] prod;
		logic signed [Q30_W-1:0]  q30;
	} mul_rsp_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quot;
	} div_rsp_t;

	// Horner coefficients, highest order first.
	function automatic logic signed [31:0] sin_coef(input logic [2:0] step);
		logic signed [31:0] c;
		case (step)
			3'd0: c = SIN_C9;
			3'd1: c = SIN_C7;
			3'd2: c = SIN_C5;
			3'd3: c = SIN_C3;
			3'd4: c = SIN_C1;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// File: src/wto_req_if.sv
// ----------------------------------------------------------------------------
// Oscillator request channel
// Valid/ready channel carrying frequency, amplitude and restart.
// ----------------------------------------------------------------------------
interface wto_req_if;
	import wto_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [FREQ_W-1:0]       frequency;
	logic signed [AMP_W-1:0] amplitude;
	logic                    restart;

	modport source(output valid, frequency, amplitude, restart, input ready);
	modport sink(input valid, frequency, amplitude, restart, output ready);
endinterface

// File: src/wto_rsp_if.sv
// ----------------------------------------------------------------------------
// Oscillator sample channel
// Valid/ready channel carrying one saturated output sample.
// ----------------------------------------------------------------------------
interface wto_rsp_if;
	import wto_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] sample;

	modport source(output valid, sample, input ready);
	modport sink(input valid, sample, output ready);
endinterface

// File: src/wto_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Sign-magnitude 32x32 multiply with a registered full product and Q0.30 form.
// ----------------------------------------------------------------------------
module wto_mul (
	input  logic             clk,
	input  wto_pkg::mul_req_t req,
	output wto_pkg::mul_rsp_t rsp
);
	import wto_pkg::*;

	logic [MUL_W-1:0]  mag_a;
	logic [MUL_W-1:0]  mag_b;
	logic              neg;
	logic [PROD_W-1:0] mag_p;
	logic [Q30_W-1:0]  mag_q;
	mul_rsp_t          mul_s1;

	assign mag_a = req.a[MUL_W-1] ? $unsigned(-req.a) : $unsigned(req.a);
	assign mag_b = req.b[MUL_W-1] ? $unsigned(-req.b) : $unsigned(req.b);
	assign neg   = req.a[MUL_W-1] ^ req.b[MUL_W-1];
	assign mag_p = PROD_W'(mag_a) * PROD_W'(mag_b);
	// Truncation toward zero: shift the magnitude, then apply the sign.
	assign mag_q = {1'b0, mag_p[PROD_W-1:30]};

	always_ff @(posedge clk) begin
		mul_s1.prod <= neg ? -$signed(mag_p) : $signed(mag_p);
		mul_s1.q30  <= neg ? -$signed(mag_q) : $signed(mag_q);
	end

	assign rsp = mul_s1;
endmodule

// File: src/wto_div.sv
// ----------------------------------------------------------------------------
// Shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wto_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wto_pkg::div_req_t req,
	output wto_pkg::div_rsp_t rsp
);
	import wto_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				den_q  <= req.den;
				quo_q  <= req.num;
			end else if (busy_q) begin
				rem_q <= ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : DIV_DEN_W'(trial);
				quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
endmodule

// File: src/wto_core.sv
// ----------------------------------------------------------------------------
// Oscillator sequencer
// Steps one request through table lookups, interpolation, gain and phase update.
// ----------------------------------------------------------------------------
module wto_core #(
	parameter int TABLE_POINTS = wto_pkg::TABLE_POINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wto_pkg::cfg_t     cfg,
	wto_req_if.sink           req,
	wto_rsp_if.source         rsp,
	output wto_pkg::mul_req_t mul_req,
	input  wto_pkg::mul_rsp_t mul_rsp,
	output wto_pkg::div_req_t div_req,
	input  wto_pkg::div_rsp_t div_rsp
);
	import wto_pkg::*;

	localparam int IDX_W = $clog2(TABLE_POINTS);
	localparam int SW    = IDX_W + 1;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_ENT     = 11'b000_0000_0010,
		S_SIN_MUL = 11'b000_0000_0100,
		S_SIN_ACC = 11'b000_0000_1000,
		S_SAW_DIV = 11'b000_0001_0000,
		S_INT_MUL = 11'b000_0010_0000,
		S_INT_ACC = 11'b000_0100_0000,
		S_AMP_MUL = 11'b000_1000_0000,
		S_AMP_ACC = 11'b001_0000_0000,
		S_INC_DIV = 11'b010_0000_0000,
		S_OUT     = 11'b100_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		SEG_RISE = 2'd0,
		SEG_FALL = 2'd1,
		SEG_TAIL = 2'd2
	} seg_t;

	state_t                  state_q;
	logic                    ent_sel_q;
	logic [IDX_W-1:0]        k_q;
	logic [15:0]             frac_q;
	logic [PHASE_W-1:0]      phase_q;
	logic [PHASE_W-1:0]      phase_acc_q;
	logic [FREQ_W-1:0]       freq_q;
	logic signed [AMP_W-1:0] amp_q;
	logic [30:0]             u_q;
	logic [1:0]              quad_q;
	logic signed [31:0]      v_q;
	logic signed [31:0]      p_q;
	logic [2:0]              sstep_q;
	seg_t                    seg_q;
	logic signed [ENT_W-1:0] a_q;
	logic signed [ENT_W-1:0] b_q;
	logic signed [ENT_W-1:0] w_q;
	logic signed [SMP_W-1:0] smp_q;
	logic                    rsp_valid_q;
	logic signed [SMP_W-1:0] rsp_sample_q;

	logic [PHASE_W-1:0]      ph_in;
	logic [SHAPE_W-1:0]      prm;
	logic [SW-1:0]           s1r, s2r, s1a, s1, s2, kx, dd;
	logic                    degen;
	seg_t                    seg;
	logic [DIV_NUM_W-1:0]    nb;
	logic                    sq_hi;
	logic [30:0]             u0, u_new;
	logic signed [Q30_W-1:0] sr;
	logic signed [ENT_W-1:0] r16, sin_val;
	logic signed [16:0]      qv, saw17;
	logic signed [ENT_W-1:0] ent_val;
	logic                    ent_done;
	logic signed [16:0]      dif;
	logic signed [63:0]      t64, p64, sum64;
	logic signed [ENT_W-1:0] t16;
	logic signed [SMP_W-1:0] sat;
	logic [RATE_W-1:0]       rate;
	logic                    out_load;

	assign ph_in = req.restart ? cfg.phase_start : phase_acc_q;

	// Saw breakpoints follow the clamped shape parameter.
	always_comb begin
		prm   = (cfg.shape_param > 17'd65536) ? 17'd65536 : cfg.shape_param;
		s1r   = SW'((34'(prm) << IDX_W) >> 17);
		s2r   = SW'((34'(18'd131072 - 18'(prm)) << IDX_W) >> 17);
		s1a   = (s1r == '0) ? SW'(1) : s1r;
		s2    = (s2r == SW'(TABLE_POINTS)) ? s2r - SW'(1) : s2r;
		s1    = (s1a == s2) ? s1a - SW'(1) : s1a;
		degen = (s1 == '0) || (s2 <= s1);
		kx    = SW'(k_q);
		if (kx <= s1) begin
			seg = SEG_RISE;
			nb  = DIV_NUM_W'(kx) << 14;
			dd  = s1;
		end else if (kx <= s2) begin
			seg = SEG_FALL;
			nb  = DIV_NUM_W'(kx - s1) << 15;
			dd  = s2 - s1;
		end else begin
			seg = SEG_TAIL;
			nb  = DIV_NUM_W'(kx - s2) << 14;
			dd  = s1;
		end
		sq_hi = (34'(k_q) << 16) < (34'(prm) << IDX_W);
	end

	// Sine entry: quarter-wave argument and final rounding; saw entry from the divider quotient.
	always_comb begin
		u0      = 31'({k_q[IDX_W-3:0], 2'b00}) << (30 - IDX_W);
		u_new   = k_q[IDX_W-2] ? ONE_Q30 - u0 : u0;
		sr      = mul_rsp.q30[Q30_W-1] ? '0 : (mul_rsp.q30 + 35'sd32768) >>> 16;
		r16     = sr[ENT_W-1:0];
		sin_val = quad_q[1] ? -r16 : r16;
		qv      = $signed({1'b0, div_rsp.quot[15:0]});
		case (seg_q)
			SEG_RISE: saw17 = qv;
			SEG_FALL: saw17 = 17'(ENT_ONE) - qv;
			SEG_TAIL: saw17 = qv - 17'(ENT_ONE);
			default:  saw17 = '0;
		endcase
	end

	always_comb begin
		ent_done = 1'b0;
		ent_val  = '0;
		case (state_q)
			S_ENT: begin
				case (cfg.wave_mode)
					WAVE_SQUARE: begin
						ent_done = 1'b1;
						ent_val  = sq_hi ? ENT_ONE : -ENT_ONE;
					end
					WAVE_SAW: ent_done = degen;
					WAVE_SILENT: ent_done = 1'b1;
					default: ent_done = 1'b0;
				endcase
			end
			S_SIN_ACC: begin
				ent_done = (sstep_q == 3'd5);
				ent_val  = sin_val;
			end
			S_SAW_DIV: begin
				ent_done = div_rsp.done;
				ent_val  = saw17[ENT_W-1:0];
			end
			default: ent_done = 1'b0;
		endcase
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		dif = {b_q[ENT_W-1], b_q} - {a_q[ENT_W-1], a_q};
		case (state_q)
			S_SIN_MUL: begin
				if (sstep_q == 3'd0) begin
					mul_req.a = $signed({1'b0, u_q});
					mul_req.b = $signed({1'b0, u_q});
				end else if (sstep_q == 3'd5) begin
					mul_req.a = p_q;
					mul_req.b = $signed({1'b0, u_q});
				end else begin
					mul_req.a = p_q;
					mul_req.b = v_q;
				end
			end
			S_INT_MUL: begin
				mul_req.a = 32'(dif);
				mul_req.b = $signed({16'b0, frac_q});
			end
			S_AMP_MUL: begin
				mul_req.a = 32'(amp_q);
				mul_req.b = 32'(w_q);
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
			end
		endcase
	end

	always_comb begin
		rate          = (cfg.sample_rate == '0) ? RATE_W'(1) : cfg.sample_rate;
		div_req.start = 1'b0;
		div_req.num   = {freq_q, 24'b0};
		div_req.den   = DIV_DEN_W'(rate);
		if (state_q == S_ENT) begin
			div_req.start = (cfg.wave_mode == WAVE_SAW) && !degen;
			div_req.num   = (nb << 1) + DIV_NUM_W'(dd);
			div_req.den   = DIV_DEN_W'({dd, 1'b0});
		end else if (state_q == S_AMP_ACC) begin
			div_req.start = 1'b1;
		end
	end

	always_comb begin
		t64   = (mul_rsp.prod + 64'sd32768) >>> 16;
		t16   = t64[ENT_W-1:0];
		p64   = (mul_rsp.prod + 64'sd8192) >>> 14;
		sum64 = p64 + 64'(cfg.level_offset);
		if (sum64 > 64'sd131071) begin
			sat = 18'sd131071;
		end else if (sum64 < -64'sd131072) begin
			sat = -18'sd131072;
		end else begin
			sat = sum64[SMP_W-1:0];
		end
	end

	assign out_load = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ent_sel_q    <= 1'b0;
			k_q          <= '0;
			frac_q       <= '0;
			phase_q      <= '0;
			phase_acc_q  <= '0;
			freq_q       <= '0;
			amp_q        <= '0;
			u_q          <= '0;
			quad_q       <= '0;
			v_q          <= '0;
			p_q          <= '0;
			sstep_q      <= '0;
			seg_q        <= SEG_RISE;
			a_q          <= '0;
			b_q          <= '0;
			w_q          <= '0;
			smp_q        <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_sample_q <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && !out_load) begin
				rsp_valid_q <= 1'b0;
			end
			if (ent_done) begin
				if (!ent_sel_q) begin
					a_q       <= ent_val;
					ent_sel_q <= 1'b1;
					k_q       <= k_q + IDX_W'(1);
					state_q   <= S_ENT;
				end else begin
					b_q     <= ent_val;
					state_q <= S_INT_MUL;
				end
			end else begin
				case (state_q)
					S_IDLE: begin
						if (req.valid) begin
							phase_q   <= ph_in;
							k_q       <= ph_in[PHASE_W-1 -: IDX_W];
							frac_q    <= ph_in[PHASE_W-1-IDX_W -: 16];
							freq_q    <= req.frequency;
							amp_q     <= req.amplitude;
							ent_sel_q <= 1'b0;
							state_q   <= S_ENT;
						end
					end
					S_ENT: begin
						if (cfg.wave_mode == WAVE_SINE) begin
							u_q     <= u_new;
							quad_q  <= k_q[IDX_W-1 -: 2];
							sstep_q <= '0;
							state_q <= S_SIN_MUL;
						end else begin
							seg_q   <= seg;
							state_q <= S_SAW_DIV;
						end
					end
					S_SIN_MUL: state_q <= S_SIN_ACC;
					S_SIN_ACC: begin
						if (sstep_q == 3'd0) begin
							v_q <= mul_rsp.q30[31:0];
							p_q <= sin_coef(3'd0);
						end else begin
							p_q <= sin_coef(sstep_q) + mul_rsp.q30[31:0];
						end
						sstep_q <= sstep_q + 3'd1;
						state_q <= S_SIN_MUL;
					end
					S_SAW_DIV: state_q <= S_SAW_DIV;
					S_INT_MUL: state_q <= S_INT_ACC;
					S_INT_ACC: begin
						w_q     <= a_q + t16;
						state_q <= S_AMP_MUL;
					end
					S_AMP_MUL: state_q <= S_AMP_ACC;
					S_AMP_ACC: begin
						smp_q   <= sat;
						state_q <= S_INC_DIV;
					end
					S_INC_DIV: begin
						if (div_rsp.done) begin
							phase_acc_q <= phase_q + div_rsp.quot[PHASE_W-1:0];
							state_q     <= S_OUT;
						end
					end
					S_OUT: begin
						if (out_load) begin
							rsp_valid_q  <= 1'b1;
							rsp_sample_q <= smp_q;
							state_q      <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = rsp_valid_q;
	assign rsp.sample = rsp_sample_q;
endmodule

// File: src/wavetable_oscillator.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator
// Phase-accumulator synthesis of sine, square and saw with linear interpolation.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// req       in         frequency (Q16.8 Hz), amplitude (Q1.14), restart
// rsp       out        sample (Q3.14, saturated)
// cfg       in         write enable, register index, 32-bit write data
//
// One request is in flight at a time; ready is low from acceptance until the
// sample is loaded into the output register. The 48-step divider forms the
// phase increment and the saw entries. The last step waits while the output
// register holds a sample that is not yet taken. Reset clears the phase and
// loads the register defaults.
module wavetable_oscillator #(
	parameter int TABLE_POINTS = wto_pkg::TABLE_POINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wto_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wto_pkg::CFG_DATA_W-1:0] cfg_data,
	wto_req_if.sink                        req,
	wto_rsp_if.source                      rsp
);
	import wto_pkg::*;

	cfg_t     cfg_q;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wave_mode    <= WAVE_SINE;
			cfg_q.shape_param  <= 17'd32768;
			cfg_q.phase_start  <= '0;
			cfg_q.level_offset <= '0;
			cfg_q.sample_rate  <= 18'd44100;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WAVE_MODE:    cfg_q.wave_mode    <= wave_t'(cfg_data[MODE_W-1:0]);
				REG_SHAPE_PARAM:  cfg_q.shape_param  <= cfg_data[SHAPE_W-1:0];
				REG_PHASE_START:  cfg_q.phase_start  <= cfg_data[PHASE_W-1:0];
				REG_LEVEL_OFFSET: cfg_q.level_offset <= cfg_data[LOFF_W-1:0];
				REG_SAMPLE_RATE:  cfg_q.sample_rate  <= cfg_data[RATE_W-1:0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	wto_core #(
		.TABLE_POINTS(TABLE_POINTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.rsp    (rsp),
		.mul_req(mul_req),
		.mul_rsp(mul_rsp),
		.div_req(div_req),
		.div_rsp(div_rsp)
	);

	wto_mul u_mul (
		.clk(clk),
		.req(mul_req),
		.rsp(mul_rsp)
	);

	wto_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);
endmodule

// File: src/wto_chk.sv
// ----------------------------------------------------------------------------
// Oscillator port checker
// Watches the request and sample channels of the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wto_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic signed [wto_pkg::SMP_W-1:0] sample
);
	import wto_pkg::*;

	// A stalled sample keeps its value.
	`ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(sample))
	// Once a request is taken the block is busy.
	`ASSERT_NXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)
	// A new sample only appears at the end of a busy period.
	`ASSERT_IMP(a_rsp_from_work, clk, arst_n, $rose(rsp_valid), !$past(req_ready))
endmodule

bind wavetable_oscillator wto_chk u_wto_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.sample   (rsp.sample)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable oscillator testbench
// Sends sample requests under several register settings, predicts each sample
// with an independent fixed-point model of the oscillator and compares the
// returned samples in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import wto_pkg::*;

	localparam int POINTS    = 2048;
	localparam int WDOG_MAX  = 4000;
	localparam int SETTLE    = 200;
	localparam int HOLD_LONG = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wto_req_if req_ch();
	wto_rsp_if rsp_ch();

	wavetable_oscillator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	// Oscillator state as the predictor sees it.
	wave_t                   osc_mode;
	logic [SHAPE_W-1:0]      osc_shape;
	logic [PHASE_W-1:0]      osc_pstart;
	logic signed [LOFF_W-1:0] osc_loff;
	logic [RATE_W-1:0]       osc_rate;
	logic [PHASE_W-1:0]      osc_phase;

	logic signed [SMP_W-1:0] expected_samples[$];
	int                      fail_count;
	int                      gap_max;
	int                      stall_max;
	int                      hold_cycles;
	int                      idle_cycles;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint q30_mul(longint a, longint b);
		logic neg;
		longint unsigned mag;
		longint unsigned r;
		neg = a < 0;
		mag = neg ? longint'(-a) : a;
		r = (mag * longint'(b)) >> 30;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint sine_value(longint unsigned k);
		longint unsigned k4;
		longint unsigned quad;
		longint unsigned rem;
		longint u;
		longint v;
		longint p;
		longint s;
		longint r;
		k4 = 4 * k;
		quad = k4 / POINTS;
		rem = k4 - quad * POINTS;
		u = longint'((rem << 30) / POINTS);
		if (quad[0]) begin
			u = longint'(ONE_Q30) - u;
		end
		v = q30_mul(u, u);
		p = longint'(SIN_C9);
		p = longint'(SIN_C7) + q30_mul(p, v);
		p = longint'(SIN_C5) + q30_mul(p, v);
		p = longint'(SIN_C3) + q30_mul(p, v);
		p = longint'(SIN_C1) + q30_mul(p, v);
		s = q30_mul(p, u);
		if (s < 0) begin
			s = 0;
		end
		r = (s + 32768) >> 16;
		return quad[1] ? -r : r;
	endfunction

	function automatic longint round_half_up(longint unsigned num, longint unsigned den);
		return longint'((2 * num + den) / (2 * den));
	endfunction

	function automatic longint table_value(longint unsigned k);
		longint unsigned prm;
		longint unsigned s1;
		longint unsigned s2;
		prm = (osc_shape > 65536) ? 65536 : osc_shape;
		case (osc_mode)
			WAVE_SINE: return sine_value(k);
			WAVE_SQUARE: return (k * 65536 < prm * POINTS) ? 16384 : -16384;
			WAVE_SAW: begin
				s1 = (prm * POINTS) / 131072;
				if (s1 == 0) s1 = 1;
				s2 = ((131072 - prm) * POINTS) / 131072;
				if (s2 == POINTS) s2--;
				if (s1 == s2) s1--;
				if (s1 == 0 || s2 <= s1) return 0;
				if (k <= s1) return round_half_up(k * 16384, s1);
				if (k <= s2) return 16384 - round_half_up(2 * (k - s1) * 16384, s2 - s1);
				return -16384 + round_half_up((k - s2) * 16384, s1);
			end
			default: return 0;
		endcase
	endfunction

	// Works out the sample for one request and advances the phase.
	function automatic logic signed [SMP_W-1:0] next_sample(
		logic [FREQ_W-1:0] freq, logic signed [AMP_W-1:0] amp, logic rst);
		longint unsigned pos;
		longint unsigned idx;
		longint unsigned nxt;
		longint unsigned rate;
		longint unsigned inc;
		longint f;
		longint a;
		longint b;
		longint w;
		longint smp;
		if (rst) begin
			osc_phase = osc_pstart;
		end
		pos = longint'(osc_phase) * POINTS;
		idx = pos >> 32;
		if (idx >= POINTS) idx = POINTS - 1;
		nxt = (idx + 1 >= POINTS) ? 0 : idx + 1;
		f = longint'((pos >> 16) & 64'hFFFF);
		a = table_value(idx);
		b = table_value(nxt);
		w = a + (((b - a) * f + 32768) >>> 16);
		smp = ((longint'(amp) * w + 8192) >>> 14) + longint'(osc_loff);
		if (smp > 131071) smp = 131071;
		if (smp < -131072) smp = -131072;
		rate = (osc_rate == 0) ? 1 : osc_rate;
		inc = (longint'(freq) << 24) / rate;
		osc_phase = osc_phase + inc[31:0];
		return smp[SMP_W-1:0];
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_WAVE_MODE: osc_mode = wave_t'(data[MODE_W-1:0]);
			REG_SHAPE_PARAM: osc_shape = data[SHAPE_W-1:0];
			REG_PHASE_START: osc_pstart = data;
			REG_LEVEL_OFFSET: osc_loff = data[LOFF_W-1:0];
			REG_SAMPLE_RATE: osc_rate = data[RATE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic setup(wave_t mode, logic [31:0] shape, logic [31:0] pstart,
		logic [31:0] loff, logic [31:0] rate);
		write_reg(REG_WAVE_MODE, CFG_DATA_W'(mode));
		write_reg(REG_SHAPE_PARAM, shape);
		write_reg(REG_PHASE_START, pstart);
		write_reg(REG_LEVEL_OFFSET, loff);
		write_reg(REG_SAMPLE_RATE, rate);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Called at a rising edge; returns at the edge where the request is taken.
	task automatic send_request(logic [FREQ_W-1:0] freq, logic signed [AMP_W-1:0] amp,
		logic rst);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.frequency <= freq;
		req_ch.amplitude <= amp;
		req_ch.restart <= rst;
		do @(posedge clk); while (!req_ch.ready);
		expected_samples.push_back(next_sample(freq, amp, rst));
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (expected_samples.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [FREQ_W-1:0] rand_freq();
		case ($urandom_range(0, 3))
			0: return FREQ_W'($urandom_range(0, 255));
			1: return FREQ_W'($urandom_range(0, 20000 * 256));
			default: return FREQ_W'($urandom_range(0, (1 << FREQ_W) - 1));
		endcase
	endfunction

	function automatic logic signed [AMP_W-1:0] rand_amp();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return AMP_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic test_field_extremes();
		setup(WAVE_SINE, 32768, 0, 0, 44100);
		send_request('0, 16'sh7FFF, 1'b1);
		send_request(24'hFFFFFF, 16'sh7FFF, 1'b0);
		send_request(24'hFFFFFF, 16'sh8000, 1'b0);
		send_request(24'h000100, 16'sh4000, 1'b0);
		send_request(24'h800000, 16'sh0000, 1'b1);
		drain();
	endtask

	task automatic test_wave_modes();
		setup(WAVE_SQUARE, 16384, 32'h4000_0000, 32'h0000_2000, 48000);
		send_request(24'h123456, 16'sh4000, 1'b1);
		send_request(24'h654321, 16'shC000, 1'b0);
		drain();
		setup(WAVE_SAW, 0, 32'hFFFF_FFFF, 32'h0000_7FFF, 1);
		send_request(24'h0001FF, 16'sh7FFF, 1'b1);
		send_request(24'hABCDEF, 16'sh7FFF, 1'b0);
		drain();
		setup(WAVE_SAW, 65536, 32'h8000_0000, 32'h0000_8000, 192000);
		send_request(24'h00FF00, 16'sh8000, 1'b1);
		send_request(24'hFFFFFF, 16'sh8000, 1'b0);
		drain();
	endtask

	task automatic test_special_cases();
		// Silent waveform leaves only the level offset.
		setup(WAVE_SILENT, 32768, 0, 32'h0000_5555, 44100);
		send_request(24'h001234, 16'sh7FFF, 1'b1);
		send_request(24'hFFFFFF, 16'sh8000, 1'b0);
		drain();
		// Shape above one, zero sample rate, and writes to unused indexes.
		setup(WAVE_SQUARE, 32'h0001_FFFF, 32'hFFFF_F000, 32'h0000_8000, 0);
		for (int i = REG_SAMPLE_RATE + 1; i < (1 << CFG_IDX_W); i++) begin
			write_reg(CFG_IDX_W'(i), $urandom());
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		send_request(24'h000001, 16'sh7FFF, 1'b1);
		send_request(24'hFFFFFF, 16'sh7FFF, 1'b0);
		send_request(24'hFFFFFF, 16'sh7FFF, 1'b0);
		drain();
		setup(WAVE_SAW, 32'h0001_0001, 0, 32'h0000_7FFF, 262143);
		send_request(24'hFFFFFF, 16'sh7FFF, 1'b1);
		send_request(24'hFFFFFF, 16'sh7FFF, 1'b0);
		drain();
	endtask

	task automatic test_backpressure();
		setup(WAVE_SINE, 32768, 0, 0, 44100);
		gap_max = 0;
		hold_cycles = HOLD_LONG;
		for (int i = 0; i < 8; i++) begin
			send_request(rand_freq(), rand_amp(), i == 0);
		end
		gap_max = 17;
		drain();
	endtask

	task automatic test_random_phases();
		wave_t mode;
		logic [31:0] shape;
		logic [31:0] rate;
		for (int ph = 0; ph < 20; ph++) begin
			mode = wave_t'($urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: shape = 0;
				1: shape = 65536;
				2: shape = $urandom_range(65537, 131071);
				default: shape = $urandom_range(0, 65536);
			endcase
			case ($urandom_range(0, 3))
				0: rate = $urandom_range(0, 3);
				1: rate = 192000;
				default: rate = $urandom_range(8000, 262143);
			endcase
			setup(mode, shape, $urandom(), $urandom(), rate);
			// Every third phase runs with no idling on either side.
			gap_max = (ph % 3 == 0) ? 0 : 17;
			stall_max = gap_max;
			for (int i = 0; i < 55; i++) begin
				send_request(rand_freq(), rand_amp(), ($urandom_range(0, 9) == 0));
			end
			drain();
		end
		gap_max = 17;
		stall_max = 17;
	endtask

	// Sample receiver with random stalls and an optional long hold-off.
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = $urandom_range(0, stall_max);
			end
			@(posedge clk);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (expected_samples.size() == 0) begin
				$error("sample %0d returned with no request outstanding", rsp_ch.sample);
				fail_count++;
			end else if (rsp_ch.sample !== expected_samples[0]) begin
				$error("sample: expected %0d, actual %0d", expected_samples[0],
					rsp_ch.sample);
				fail_count++;
				void'(expected_samples.pop_front());
			end else begin
				void'(expected_samples.pop_front());
			end
		end
	end

	// Watchdog: ends the run when no request or sample moves for too long.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_MAX) begin
			$display("FAIL wavetable_oscillator");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.frequency = '0;
		req_ch.amplitude = '0;
		req_ch.restart = 1'b0;
		fail_count = 0;
		gap_max = 17;
		stall_max = 17;
		hold_cycles = 0;
		idle_cycles = 0;
		osc_mode = WAVE_SINE;
		osc_shape = 32768;
		osc_pstart = '0;
		osc_loff = '0;
		osc_rate = 44100;
		osc_phase = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// A few requests on the reset defaults first.
		for (int i = 0; i < 3; i++) begin
			send_request(rand_freq(), rand_amp(), 1'b0);
		end
		drain();
		test_field_extremes();
		test_wave_modes();
		test_special_cases();
		test_backpressure();
		test_random_phases();
		drain();
		if (expected_samples.size() > 0) begin
			$error("%0d samples never returned", expected_samples.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("PASS wavetable_oscillator");
		end else begin
			$display("FAIL wavetable_oscillator");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/wto_pkg.sv
src/wto_req_if.sv
src/wto_rsp_if.sv
src/wto_mul.sv
src/wto_div.sv
src/wto_core.sv
src/wavetable_oscillator.sv
src/wto_chk.sv
dv/tb_top.sv
